@@ sv/sct_pkg.sv @@
// shared types, constants and helper functions for the source character tokenizer
// no dependencies; every other file imports this package
package sct_pkg;

  // counter widths and keyword prefix size
  localparam int LINE_BITS     = 16;
  localparam int COLUMN_BITS   = 16;
  localparam int LENGTH_BITS   = 8;
  localparam int KEYWORD_CHARS = 5;

  // queue between front and back, and result buffer at the output
  localparam int QUEUE_DEPTH  = 4;
  localparam int RESULT_DEPTH = 4;

  // characters with a role of their own
  localparam logic [7:0] CH_NUL        = 8'd0;
  localparam logic [7:0] CH_LF         = 8'd10;
  localparam logic [7:0] CH_CR         = 8'd13;
  localparam logic [7:0] CH_SPACE      = 8'd32;
  localparam logic [7:0] CH_BANG       = 8'd33;
  localparam logic [7:0] CH_LESS       = 8'd60;
  localparam logic [7:0] CH_EQUAL      = 8'd61;
  localparam logic [7:0] CH_GREATER    = 8'd62;
  localparam logic [7:0] CH_UNDERSCORE = 8'd95;

  typedef enum logic [4:0] {
    TK_PLUS   = 5'd0,
    TK_MINUS  = 5'd1,
    TK_STAR   = 5'd2,
    TK_SLASH  = 5'd3,
    TK_MODULO = 5'd4,
    TK_LPAREN = 5'd5,
    TK_RPAREN = 5'd6,
    TK_LBRACE = 5'd7,
    TK_RBRACE = 5'd8,
    TK_SEMI   = 5'd9,
    TK_EQU    = 5'd10,
    TK_ASSIGN = 5'd11,
    TK_NEQ    = 5'd12,
    TK_NOT    = 5'd13,
    TK_GT     = 5'd14,
    TK_LT     = 5'd15,
    TK_GEQ    = 5'd16,
    TK_LEQ    = 5'd17,
    TK_INTLIT = 5'd18,
    TK_IDENT  = 5'd19,
    TK_PRINT  = 5'd20,
    TK_IF     = 5'd21,
    TK_ELSE   = 5'd22,
    TK_WHILE  = 5'd23,
    TK_FOR    = 5'd24,
    TK_I32    = 5'd25,
    TK_VOID   = 5'd26,
    TK_BYTE   = 5'd27,
    TK_EOF    = 5'd28,
    TK_ERROR  = 5'd29
  } token_kind_t;

  typedef enum logic [3:0] {
    CL_END,
    CL_NEWLINE,
    CL_BLANK,
    CL_OPSTART,
    CL_SINGLE,
    CL_DIGIT,
    CL_ALPHA,
    CL_UNDERSCORE,
    CL_OTHER
  } char_class_t;

  // one classified byte, as queued between front and back
  typedef struct packed {
    logic [7:0]  code;
    char_class_t cls;
    token_kind_t single;
  } char_item_t;

  // one token as delivered on the output channel
  typedef struct packed {
    token_kind_t kind;
    logic [15:0] line;
    logic [15:0] column;
    logic [7:0]  length;
    logic [31:0] value;
    logic        overflow;
    logic [7:0]  bad;
    logic        last;
  } token_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  typedef logic [KEYWORD_CHARS-1:0][7:0] prefix_t;

  // saturate to the output field widths
  function automatic logic [15:0] clamp16(input logic [31:0] v);
    return (v > 32'd65535) ? 16'hFFFF : v[15:0];
  endfunction

  function automatic logic [7:0] clamp8(input logic [15:0] v);
    return (v > 16'd255) ? 8'hFF : v[7:0];
  endfunction

  function automatic token_t make_token(input token_kind_t k, input logic [31:0] line,
                                        input logic [31:0] col, input logic [15:0] len,
                                        input logic [31:0] val, input logic ovf,
                                        input logic [7:0] bad);
    token_t t;
    t.kind     = k;
    t.line     = clamp16(line);
    t.column   = clamp16(col);
    t.length   = clamp8(len);
    t.value    = val;
    t.overflow = ovf;
    t.bad      = bad;
    t.last     = 1'b0;
    return t;
  endfunction

  // keyword table: length, kind and zero padded text
  function automatic logic [3:0] kw_len(input logic [2:0] idx);
    case (idx)
      3'd0:    return 4'd5;
      3'd1:    return 4'd2;
      3'd2:    return 4'd4;
      3'd3:    return 4'd5;
      3'd4:    return 4'd3;
      3'd5:    return 4'd3;
      3'd6:    return 4'd4;
      default: return 4'd4;
    endcase
  endfunction

  function automatic token_kind_t kw_kind(input logic [2:0] idx);
    case (idx)
      3'd0:    return TK_PRINT;
      3'd1:    return TK_IF;
      3'd2:    return TK_ELSE;
      3'd3:    return TK_WHILE;
      3'd4:    return TK_FOR;
      3'd5:    return TK_I32;
      3'd6:    return TK_VOID;
      default: return TK_BYTE;
    endcase
  endfunction

  function automatic prefix_t kw_text(input logic [2:0] idx);
    logic [39:0] s;
    int          n;
    prefix_t     p;
    n = int'(kw_len(idx));
    p = '0;
    case (idx)
      3'd0:    s = "print";
      3'd1:    s = "if";
      3'd2:    s = "else";
      3'd3:    s = "while";
      3'd4:    s = "for";
      3'd5:    s = "i32";
      3'd6:    s = "void";
      default: s = "byte";
    endcase
    for (int k = 0; k < KEYWORD_CHARS; k++) begin
      if (k < n) begin
        p[k] = s[8*(n-1-k) +: 8];
      end
    end
    return p;
  endfunction

  // keyword or plain identifier; the prefix is zero past the stored characters
  function automatic token_kind_t word_kind(input prefix_t prefix,
                                            input logic [LENGTH_BITS-1:0] len);
    token_kind_t k;
    k = TK_IDENT;
    for (int i = 7; i >= 0; i--) begin
      if (len == LENGTH_BITS'(kw_len(3'(i))) && prefix == kw_text(3'(i))) begin
        k = kw_kind(3'(i));
      end
    end
    return k;
  endfunction

  // operator kinds for a pending = ! < >
  function automatic token_kind_t single_kind(input logic [7:0] op);
    case (op)
      CH_EQUAL: return TK_ASSIGN;
      CH_BANG:  return TK_NOT;
      CH_LESS:  return TK_LT;
      default:  return TK_GT;
    endcase
  endfunction

  function automatic token_kind_t double_kind(input logic [7:0] op);
    case (op)
      CH_EQUAL: return TK_EQU;
      CH_BANG:  return TK_NEQ;
      CH_LESS:  return TK_LEQ;
      default:  return TK_GEQ;
    endcase
  endfunction

endpackage

@@ sv/sct_if.sv @@
// channel interfaces: source bytes in, tokens out
// depends on sct_pkg for the token kind type
interface sct_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] source_byte;

  modport source (output valid, output source_byte, input ready);
  modport sink (input valid, input source_byte, output ready);
endinterface

interface sct_token_if import sct_pkg::*;;
  logic        valid;
  logic        ready;
  token_kind_t token_kind;
  logic [15:0] start_line;
  logic [15:0] start_column;
  logic [7:0]  token_length;
  logic [31:0] literal_value;
  logic        literal_overflow;
  logic [7:0]  bad_byte;
  logic        last_of_run;

  modport source (output valid, output token_kind, output start_line, output start_column,
                  output token_length, output literal_value, output literal_overflow,
                  output bad_byte, output last_of_run, input ready);
  modport sink (input valid, input token_kind, input start_line, input start_column,
                input token_length, input literal_value, input literal_overflow,
                input bad_byte, input last_of_run, output ready);
endinterface

@@ sv/source_char_tokenizer.sv @@
// top level of the source character tokenizer: front end, byte queue, scanner
// depends on sct_pkg, sct_if, sct_front, sct_queue and sct_back
//
//   port    dir  beat
//   chars   in   one source byte; zero ends the input
//   tokens  out  one token: kind, position, length, literal value, error byte
//
// one byte is taken per cycle while the queue has room; each byte is registered in
// the byte queue and its tokens in the result buffer. a byte that closes a token and
// forms another gives two tokens, which the channel sends one per cycle in turn.
// a four entry byte queue and a four slot result buffer let either side stall alone;
// the scanner takes a byte only when two result slots are free.
// rst is synchronous; after reset, and after each end of input, line and column are 1.
module source_char_tokenizer import sct_pkg::*; (
  input logic          clk,
  input logic          rst,
  sct_char_if.sink     chars,
  sct_token_if.source  tokens
);

  queue_status_t status;
  logic          push;
  logic          pop;
  char_item_t    push_item;
  char_item_t    pop_item;

  sct_front u_front (
    .chars  (chars),
    .status (status),
    .push   (push),
    .item   (push_item)
  );

  sct_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .status    (status),
    .pop       (pop),
    .pop_item  (pop_item)
  );

  sct_back u_back (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .item   (pop_item),
    .pop    (pop),
    .tokens (tokens)
  );

endmodule

@@ sv/sct_front.sv @@
// front end: takes source bytes and classifies them for the scanner
// depends on sct_pkg and sct_char_if
module sct_front import sct_pkg::*; (
  sct_char_if.sink      chars,
  input  queue_status_t status,
  output logic          push,
  output char_item_t    item
);

  // accept whenever the queue has room
  assign chars.ready = !status.full;
  assign push        = chars.valid && !status.full;

  // character class decode
  always_comb begin
    item.code   = chars.source_byte;
    item.single = TK_PLUS;
    unique case (chars.source_byte) inside
      CH_NUL:                      item.cls = CL_END;
      CH_LF:                       item.cls = CL_NEWLINE;
      CH_CR, CH_SPACE:             item.cls = CL_BLANK;
      CH_EQUAL, CH_BANG, CH_LESS,
      CH_GREATER:                  item.cls = CL_OPSTART;
      "+": begin item.cls = CL_SINGLE; item.single = TK_PLUS;   end
      "-": begin item.cls = CL_SINGLE; item.single = TK_MINUS;  end
      "*": begin item.cls = CL_SINGLE; item.single = TK_STAR;   end
      "/": begin item.cls = CL_SINGLE; item.single = TK_SLASH;  end
      "%": begin item.cls = CL_SINGLE; item.single = TK_MODULO; end
      "(": begin item.cls = CL_SINGLE; item.single = TK_LPAREN; end
      ")": begin item.cls = CL_SINGLE; item.single = TK_RPAREN; end
      "{": begin item.cls = CL_SINGLE; item.single = TK_LBRACE; end
      "}": begin item.cls = CL_SINGLE; item.single = TK_RBRACE; end
      ";": begin item.cls = CL_SINGLE; item.single = TK_SEMI;   end
      ["0":"9"]:                   item.cls = CL_DIGIT;
      ["a":"z"], ["A":"Z"]:        item.cls = CL_ALPHA;
      CH_UNDERSCORE:               item.cls = CL_UNDERSCORE;
      default:                     item.cls = CL_OTHER;
    endcase
  end

endmodule

@@ sv/sct_queue.sv @@
// short queue of classified bytes between the front end and the scanner
// depends on sct_pkg
module sct_queue import sct_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  char_item_t    push_item,
  output queue_status_t status,
  input  logic          pop,
  output char_item_t    pop_item
);

  localparam int PTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int COUNT_BITS = $clog2(QUEUE_DEPTH + 1);

  char_item_t            mem [QUEUE_DEPTH];
  logic [PTR_BITS-1:0]   wr_ptr;
  logic [PTR_BITS-1:0]   rd_ptr;
  logic [COUNT_BITS-1:0] count;

  assign status.full  = (count == COUNT_BITS'(QUEUE_DEPTH));
  assign status.empty = (count == '0);
  assign pop_item     = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + COUNT_BITS'(push) - COUNT_BITS'(pop);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= COUNT_BITS'(QUEUE_DEPTH))
    else $error("queue fill level beyond depth");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> count != '0)
    else $error("queue popped while empty");

  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> count == $past(count) + 1'b1)
    else $error("queue fill level did not follow a push");

endmodule

@@ sv/sct_back.sv @@
// back end: scanner state machine and result buffer driving the token channel
// depends on sct_pkg and sct_token_if
module sct_back import sct_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  queue_status_t status,
  input  char_item_t    item,
  output logic          pop,
  sct_token_if.source   tokens
);

  localparam int RPTR_BITS  = $clog2(RESULT_DEPTH);
  localparam int RCOUNT_BITS = $clog2(RESULT_DEPTH + 1);

  typedef enum logic [1:0] {M_IDLE, M_NUMBER, M_WORD, M_PENDING} mode_t;

  mode_t                   mode, mode_next;
  logic [7:0]              pending_op, pending_op_next;
  logic [LINE_BITS-1:0]    line, line_next;
  logic [COLUMN_BITS-1:0]  column, column_next;
  logic [LINE_BITS-1:0]    tok_line, tok_line_next;
  logic [COLUMN_BITS-1:0]  tok_column, tok_column_next;
  logic [LENGTH_BITS-1:0]  length, length_next;
  logic [31:0]             acc, acc_next;
  logic                    ovf, ovf_next;
  prefix_t                 prefix, prefix_next;

  token_t                  tok_a, tok_b, res0, res1;
  logic                    has_a, has_b, fall_idle;
  logic [35:0]             acc_ten;
  logic [1:0]              push_n;
  logic [COLUMN_BITS-1:0]  column_inc;
  logic [LENGTH_BITS-1:0]  length_inc;

  token_t                  rbuf [RESULT_DEPTH];
  logic [RPTR_BITS-1:0]    rwr, rrd;
  logic [RCOUNT_BITS-1:0]  rcount;
  logic                    out_pop;

  // take a byte only when two result slots are free
  assign pop = !status.empty && (rcount <= RCOUNT_BITS'(RESULT_DEPTH - 2));

  assign column_inc = (column == '1) ? column : column + 1'b1;
  assign length_inc = (length == '1) ? length : length + 1'b1;
  assign acc_ten = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {32'd0, item.code[3:0]};

  // scanner next state and up to two tokens per byte
  always_comb begin
    mode_next       = mode;
    pending_op_next = pending_op;
    line_next       = line;
    column_next     = column;
    tok_line_next   = tok_line;
    tok_column_next = tok_column;
    length_next     = length;
    acc_next        = acc;
    ovf_next        = ovf;
    prefix_next     = prefix;
    tok_a           = '0;
    tok_b           = '0;
    has_a           = 1'b0;
    has_b           = 1'b0;
    fall_idle       = 1'b1;

    // finish or extend a token in progress
    unique case (mode)
      M_NUMBER: begin
        if (item.cls == CL_DIGIT) begin
          if (acc_ten[35:32] != 4'd0) begin
            acc_next = '1;
            ovf_next = 1'b1;
          end else begin
            acc_next = acc_ten[31:0];
          end
          length_next = length_inc;
          column_next = column_inc;
          fall_idle   = 1'b0;
        end else begin
          has_a     = 1'b1;
          tok_a     = make_token(TK_INTLIT, 32'(tok_line), 32'(tok_column),
                                 16'(length), acc, ovf, 8'd0);
          mode_next = M_IDLE;
        end
      end
      M_WORD: begin
        if (item.cls == CL_ALPHA || item.cls == CL_DIGIT || item.cls == CL_UNDERSCORE) begin
          for (int i = 0; i < KEYWORD_CHARS; i++) begin
            if (length == LENGTH_BITS'(i)) begin
              prefix_next[i] = item.code;
            end
          end
          length_next = length_inc;
          column_next = column_inc;
          fall_idle   = 1'b0;
        end else begin
          has_a     = 1'b1;
          tok_a     = make_token(word_kind(prefix, length), 32'(tok_line),
                                 32'(tok_column), 16'(length), 32'd0, 1'b0, 8'd0);
          mode_next = M_IDLE;
        end
      end
      M_PENDING: begin
        has_a     = 1'b1;
        mode_next = M_IDLE;
        if (item.code == CH_EQUAL) begin
          tok_a       = make_token(double_kind(pending_op), 32'(tok_line),
                                   32'(tok_column), 16'd2, 32'd0, 1'b0, 8'd0);
          column_next = column_inc;
          fall_idle   = 1'b0;
        end else begin
          tok_a = make_token(single_kind(pending_op), 32'(tok_line),
                             32'(tok_column), 16'd1, 32'd0, 1'b0, 8'd0);
        end
      end
      default: ;
    endcase

    // the byte as seen between tokens
    if (fall_idle) begin
      unique case (item.cls)
        CL_END: begin
          has_b           = 1'b1;
          tok_b           = make_token(TK_EOF, 32'(line),
                                       (column > 1) ? 32'(column) - 32'd1 : 32'd0,
                                       16'd0, 32'd0, 1'b0, 8'd0);
          mode_next       = M_IDLE;
          pending_op_next = '0;
          line_next       = LINE_BITS'(1);
          column_next     = COLUMN_BITS'(1);
          tok_line_next   = '0;
          tok_column_next = '0;
          length_next     = '0;
          acc_next        = '0;
          ovf_next        = 1'b0;
          prefix_next     = '0;
        end
        CL_NEWLINE: begin
          line_next   = (line == '1) ? line : line + 1'b1;
          column_next = COLUMN_BITS'(1);
        end
        CL_BLANK: begin
          column_next = column_inc;
        end
        CL_OPSTART: begin
          mode_next       = M_PENDING;
          pending_op_next = item.code;
          tok_line_next   = line;
          tok_column_next = column;
          length_next     = LENGTH_BITS'(1);
          column_next     = column_inc;
        end
        CL_SINGLE: begin
          has_b       = 1'b1;
          tok_b       = make_token(item.single, 32'(line), 32'(column), 16'd1,
                                   32'd0, 1'b0, 8'd0);
          column_next = column_inc;
        end
        CL_DIGIT: begin
          mode_next       = M_NUMBER;
          tok_line_next   = line;
          tok_column_next = column;
          length_next     = LENGTH_BITS'(1);
          acc_next        = {28'd0, item.code[3:0]};
          ovf_next        = 1'b0;
          column_next     = column_inc;
        end
        CL_ALPHA: begin
          mode_next       = M_WORD;
          tok_line_next   = line;
          tok_column_next = column;
          length_next     = LENGTH_BITS'(1);
          prefix_next     = '0;
          prefix_next[0]  = item.code;
          column_next     = column_inc;
        end
        default: begin
          has_b       = 1'b1;
          tok_b       = make_token(TK_ERROR, 32'(line), 32'(column), 16'd1,
                                   32'd0, 1'b0, item.code);
          column_next = column_inc;
        end
      endcase
    end

    // order the results and mark the last one of this byte
    res0      = has_a ? tok_a : tok_b;
    res0.last = !(has_a && has_b);
    res1      = tok_b;
    res1.last = 1'b1;
    push_n    = {1'b0, has_a} + {1'b0, has_b};
  end

  // scanner registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= M_IDLE;
      pending_op <= '0;
      line       <= LINE_BITS'(1);
      column     <= COLUMN_BITS'(1);
      tok_line   <= '0;
      tok_column <= '0;
      length     <= '0;
      acc        <= '0;
      ovf        <= 1'b0;
      prefix     <= '0;
    end else if (pop) begin
      mode       <= mode_next;
      pending_op <= pending_op_next;
      line       <= line_next;
      column     <= column_next;
      tok_line   <= tok_line_next;
      tok_column <= tok_column_next;
      length     <= length_next;
      acc        <= acc_next;
      ovf        <= ovf_next;
      prefix     <= prefix_next;
    end
  end

  // result buffer storage
  always_ff @(posedge clk) begin
    if (pop && push_n != 2'd0) begin
      rbuf[rwr] <= res0;
    end
    if (pop && push_n == 2'd2) begin
      rbuf[rwr + 1'b1] <= res1;
    end
  end

  // result buffer pointers
  assign out_pop = tokens.valid && tokens.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rwr    <= '0;
      rrd    <= '0;
      rcount <= '0;
    end else begin
      if (pop) begin
        rwr <= rwr + RPTR_BITS'(push_n);
      end
      if (out_pop) begin
        rrd <= rrd + 1'b1;
      end
      rcount <= rcount + (pop ? RCOUNT_BITS'(push_n) : '0) - RCOUNT_BITS'(out_pop);
    end
  end

  // output channel
  assign tokens.valid            = (rcount != '0);
  assign tokens.token_kind       = rbuf[rrd].kind;
  assign tokens.start_line       = rbuf[rrd].line;
  assign tokens.start_column     = rbuf[rrd].column;
  assign tokens.token_length     = rbuf[rrd].length;
  assign tokens.literal_value    = rbuf[rrd].value;
  assign tokens.literal_overflow = rbuf[rrd].overflow;
  assign tokens.bad_byte         = rbuf[rrd].bad;
  assign tokens.last_of_run      = rbuf[rrd].last;

  a_rbuf_bound: assert property (@(posedge clk) disable iff (rst)
    rcount <= RCOUNT_BITS'(RESULT_DEPTH))
    else $error("result buffer overfilled");

  a_eof_restart: assert property (@(posedge clk) disable iff (rst)
    (pop && item.cls == CL_END) |=>
      (mode == M_IDLE && line == LINE_BITS'(1) && column == COLUMN_BITS'(1)))
    else $error("scanner did not restart after end of input");

  a_value_only_literal: assert property (@(posedge clk) disable iff (rst)
    (tokens.valid && tokens.token_kind != TK_INTLIT) |->
      (tokens.literal_value == '0 && !tokens.literal_overflow))
    else $error("literal value on a token that is not a literal");

endmodule
